@@ rtl/core/arq_pkg.sv @@
// Types and constants shared by the stop-and-wait ARQ endpoint.
package arq_pkg;

	localparam int unsigned HEADER_BYTES  = 10;
	localparam int unsigned MAX_PAYLOAD   = 500;
	localparam int unsigned LEN_MAX       = 511;
	localparam int unsigned TIMEOUT_RESET = 1000;
	localparam int unsigned QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_PACKET = 2'd1,
		ACT_SEND   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_DELIVER = 3'd1,
		CMD_REACK   = 3'd2,
		CMD_SEND    = 3'd3,
		CMD_RETX    = 3'd4,
		CMD_PAUSE   = 3'd5,
		CMD_RESUME  = 3'd6
	} cmd_t;

	// Event classes as decided by the front end, independent of link state.
	typedef enum logic [2:0] {
		EV_NONE,
		EV_TICK,
		EV_DATA,
		EV_ACK,
		EV_SEND,
		EV_SEND_EMPTY
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic       seq_bit;
		logic [8:0] len;
	} event_t;

endpackage

@@ rtl/core/arq_in_if.sv @@
// Request channel carrying link and timer events into the endpoint.
interface arq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic        pkt_is_ack;
	logic        checksum_ok;
	logic [15:0] pkt_seq;
	logic [15:0] pkt_ack;
	logic [8:0]  app_len;

	modport source (
		output valid, action, pkt_is_ack, checksum_ok, pkt_seq, pkt_ack, app_len,
		input  ready
	);
	modport sink (
		input  valid, action, pkt_is_ack, checksum_ok, pkt_seq, pkt_ack, app_len,
		output ready
	);
endinterface

@@ rtl/core/arq_out_if.sv @@
// Request channel carrying commands out of the endpoint.
interface arq_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic       seq_out;
	logic [8:0] length_out;

	modport source (
		output valid, command, seq_out, length_out,
		input  ready
	);
	modport sink (
		input  valid, command, seq_out, length_out,
		output ready
	);
endinterface

@@ rtl/core/arq_front.sv @@
// Front end: accepts event requests and classifies them without touching link state.
module arq_front (
	arq_in_if.sink           events,
	input  logic             room,
	output logic             push,
	output arq_pkg::event_t  push_data
);

	localparam logic [10:0] MaxPay  = 11'(arq_pkg::MAX_PAYLOAD);
	localparam logic [11:0] Header  = 12'(arq_pkg::HEADER_BYTES);
	localparam logic [11:0] LenMax  = 12'(arq_pkg::LEN_MAX);

	logic [10:0] app_ext;
	logic [10:0] pay;
	logic [11:0] frame_len;

	assign events.ready = room;
	assign push         = events.valid && room;

	// Payload is capped first, then the header is added and the sum saturates.
	assign app_ext   = 11'(events.app_len);
	assign pay       = (app_ext > MaxPay) ? MaxPay : app_ext;
	assign frame_len = 12'(pay) + Header;

	always_comb begin
		push_data.kind    = arq_pkg::EV_NONE;
		push_data.seq_bit = 1'b0;
		push_data.len     = (frame_len > LenMax) ? LenMax[8:0] : frame_len[8:0];
		case (events.action)
			arq_pkg::ACT_TICK: begin
				push_data.kind = arq_pkg::EV_TICK;
			end
			arq_pkg::ACT_PACKET: begin
				if (events.checksum_ok) begin
					if (!events.pkt_is_ack) begin
						if (events.pkt_seq[15:1] == 15'd0) begin
							push_data.kind    = arq_pkg::EV_DATA;
							push_data.seq_bit = events.pkt_seq[0];
						end
					end else if (events.pkt_ack[15:1] == 15'd0) begin
						push_data.kind    = arq_pkg::EV_ACK;
						push_data.seq_bit = events.pkt_ack[0];
					end
				end
			end
			arq_pkg::ACT_SEND: begin
				push_data.kind = (events.app_len == 9'd0) ? arq_pkg::EV_SEND_EMPTY
				                                          : arq_pkg::EV_SEND;
			end
			default: begin
				push_data.kind = arq_pkg::EV_NONE;
			end
		endcase
	end

endmodule

@@ rtl/core/arq_queue.sv @@
// Short first-in first-out queue of classified events between front and back end.
module arq_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  arq_pkg::event_t  push_data,
	output logic             room,
	input  logic             pop,
	output logic             pop_valid,
	output arq_pkg::event_t  pop_data
);

	localparam int PW = (arq_pkg::QUEUE_DEPTH > 1) ? $clog2(arq_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(arq_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LastPtr = PW'(arq_pkg::QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] Depth   = CW'(arq_pkg::QUEUE_DEPTH);
	localparam logic [CW-1:0] OneItem = CW'(1);

	arq_pkg::event_t entry_q [arq_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign room      = (count_q != Depth);
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !(pop && pop_valid)) begin
				count_q <= count_q + OneItem;
			end else if (!push && pop && pop_valid) begin
				count_q <= count_q - OneItem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/arq_back.sv @@
// Back end: holds the link state, executes classified events and registers the command.
module arq_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [23:0]      cfg_wdata,
	input  logic             pop_valid,
	input  arq_pkg::event_t  pop_data,
	output logic             pop,
	arq_out_if.source        commands
);

	logic [23:0]   timeout_q;
	logic          send_bit_q;
	logic          expect_bit_q;
	logic          awaiting_ack_q;
	logic [23:0]   retry_countdown_q;
	logic [8:0]    held_length_q;

	logic          out_valid_q;
	arq_pkg::cmd_t command_q;
	logic          seq_out_q;
	logic [8:0]    length_out_q;

	logic [23:0]   reload;
	arq_pkg::cmd_t cmd_d;
	logic          seq_d;
	logic [8:0]    len_d;
	logic          send_bit_d;
	logic          expect_bit_d;
	logic          awaiting_ack_d;
	logic [23:0]   retry_countdown_d;
	logic [8:0]    held_length_d;

	// An event is executed whenever the output register is free or being emptied.
	assign pop    = pop_valid && (!out_valid_q || commands.ready);
	assign reload = (timeout_q == 24'd0) ? 24'd1 : timeout_q;

	always_comb begin
		cmd_d             = arq_pkg::CMD_NONE;
		seq_d             = 1'b0;
		len_d             = 9'd0;
		send_bit_d        = send_bit_q;
		expect_bit_d      = expect_bit_q;
		awaiting_ack_d    = awaiting_ack_q;
		retry_countdown_d = retry_countdown_q;
		held_length_d     = held_length_q;
		case (pop_data.kind)
			arq_pkg::EV_TICK: begin
				if (awaiting_ack_q) begin
					if (retry_countdown_q[23:1] != 23'd0) begin
						retry_countdown_d = retry_countdown_q - 24'd1;
					end else begin
						retry_countdown_d = reload;
						cmd_d             = arq_pkg::CMD_RETX;
						seq_d             = send_bit_q;
						len_d             = held_length_q;
					end
				end
			end
			arq_pkg::EV_DATA: begin
				// A sequence bit other than the expected one is the previous frame again.
				if (pop_data.seq_bit == expect_bit_q) begin
					cmd_d        = arq_pkg::CMD_DELIVER;
					expect_bit_d = ~expect_bit_q;
				end else begin
					cmd_d = arq_pkg::CMD_REACK;
				end
				seq_d = pop_data.seq_bit;
			end
			arq_pkg::EV_ACK: begin
				if (awaiting_ack_q && (pop_data.seq_bit == send_bit_q)) begin
					cmd_d             = arq_pkg::CMD_RESUME;
					seq_d             = send_bit_q;
					awaiting_ack_d    = 1'b0;
					retry_countdown_d = 24'd0;
					send_bit_d        = ~send_bit_q;
				end
			end
			arq_pkg::EV_SEND: begin
				if (awaiting_ack_q) begin
					cmd_d = arq_pkg::CMD_PAUSE;
					seq_d = send_bit_q;
				end else begin
					cmd_d             = arq_pkg::CMD_SEND;
					seq_d             = send_bit_q;
					len_d             = pop_data.len;
					held_length_d     = pop_data.len;
					awaiting_ack_d    = 1'b1;
					retry_countdown_d = reload;
				end
			end
			arq_pkg::EV_SEND_EMPTY: begin
				if (awaiting_ack_q) begin
					cmd_d = arq_pkg::CMD_PAUSE;
					seq_d = send_bit_q;
				end
			end
			default: begin
				cmd_d = arq_pkg::CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q         <= 24'(arq_pkg::TIMEOUT_RESET);
			send_bit_q        <= 1'b1;
			expect_bit_q      <= 1'b1;
			awaiting_ack_q    <= 1'b0;
			retry_countdown_q <= 24'd0;
			held_length_q     <= 9'd0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (pop) begin
				send_bit_q        <= send_bit_d;
				expect_bit_q      <= expect_bit_d;
				awaiting_ack_q    <= awaiting_ack_d;
				retry_countdown_q <= retry_countdown_d;
				held_length_q     <= held_length_d;
				out_valid_q       <= 1'b1;
			end else if (commands.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			command_q    <= cmd_d;
			seq_out_q    <= seq_d;
			length_out_q <= len_d;
		end
	end

	assign commands.valid      = out_valid_q;
	assign commands.command    = command_q;
	assign commands.seq_out    = seq_out_q;
	assign commands.length_out = length_out_q;

	a_idle_no_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		!awaiting_ack_q |-> (retry_countdown_q == 24'd0))
		else $error("retry countdown running while no ack is awaited");

	a_held_frame_has_header: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_ack_q |-> (held_length_q >= 9'(arq_pkg::HEADER_BYTES)))
		else $error("held frame shorter than its header while awaiting ack");

	a_resume_ends_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (command_q == arq_pkg::CMD_RESUME)) |-> !awaiting_ack_q)
		else $error("resume shown while still awaiting ack");

	a_send_starts_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (command_q == arq_pkg::CMD_SEND))
		|-> (awaiting_ack_q && (held_length_q == length_out_q)))
		else $error("send shown without a matching held frame");

endmodule

@@ rtl/core/stop_and_wait_arq_endpoint.sv @@
// Stop-and-wait ARQ endpoint: classifies link and timer events, keeps the
// alternating-bit sender and receiver state and answers each event request with
// exactly one command request. It takes one event per clock cycle and gives
// one command per cycle while the command side is ready; an event is held in
// the event queue register, then its command in the command output register.
// The two-entry event queue holds up to two events while the command side
// stalls. The timeout register may be written only while no event is in flight.
module stop_and_wait_arq_endpoint (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	arq_in_if.sink      events,
	arq_out_if.source   commands
);

	logic            push;
	logic            room;
	logic            pop;
	logic            pop_valid;
	arq_pkg::event_t push_data;
	arq_pkg::event_t pop_data;

	arq_front u_front (
		.events    (events),
		.room      (room),
		.push      (push),
		.push_data (push_data)
	);

	arq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.room      (room),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	arq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.commands  (commands)
	);

endmodule
